// ===== rtl/rpdr_pkg.sv =====
// Shared types and constants for the packet receive dedup relay.
// Used by the history cells, the history chain, the output buffer and the top level.
package rpdr_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int NUM_W = 7;
  localparam int ACK_FLAG_BIT = 7;
  localparam logic [7:0] ACK_HOPS = 8'd5;

  typedef enum logic [1:0] {
    ST_DELIVER = 2'd0,
    ST_ACK     = 2'd1,
    ST_OTHER   = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
  } entry_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] delivered_byte;
    logic       was_new;
    logic       send_valid;
    logic [7:0] send_src;
    logic [7:0] send_dst;
    logic [7:0] send_ident;
    logic [7:0] send_hops;
    logic [7:0] send_byte;
  } result_t;

endpackage

// ===== rtl/rpdr_cell.sv =====
// One history cell: holds a packet number and its valid bit, compares it with the probe.
// Depends on rpdr_pkg.
module rpdr_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  rpdr_pkg::entry_t         prev,
  input  logic [rpdr_pkg::NUM_W-1:0] probe,
  output rpdr_pkg::entry_t         entry,
  output logic                     hit
);
  import rpdr_pkg::*;

  logic             valid;
  logic [NUM_W-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      num <= prev.num;
    end
  end

  assign entry = '{valid: valid, num: num};
  assign hit   = valid && (num == probe);
endmodule

// ===== rtl/rpdr_history.sv =====
// Row of history cells that keeps the most recent packet numbers, newest at the head.
// Depends on rpdr_pkg and rpdr_cell.
module rpdr_history #(
  parameter int DEPTH = rpdr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       insert,
  input  logic [rpdr_pkg::NUM_W-1:0] probe,
  output logic                       hit
);
  import rpdr_pkg::*;

  entry_t           chain [DEPTH+1];
  logic [DEPTH-1:0] hits;

  assign chain[0] = '{valid: 1'b1, num: probe};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rpdr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (insert),
      .prev  (chain[i]),
      .probe (probe),
      .entry (chain[i+1]),
      .hit   (hits[i])
    );
  end

  assign hit = |hits;
endmodule

// ===== rtl/rpdr_outbuf.sv =====
// Two-entry output buffer: an output register backed by a skid register.
// Depends on rpdr_pkg.
module rpdr_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpdr_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rpdr_pkg::result_t out_data
);
  import rpdr_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_load;
  logic    skid_load;

  assign in_ready  = !skid_valid;
  assign out_load  = out_ready || !out_valid;
  assign skid_load = !out_load && in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (skid_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (skid_load) begin
      skid_data <= in_data;
    end
  end
endmodule

// ===== rtl/packet_receive_dedup_relay.sv =====
// Top level of the packet receive dedup relay: decision logic, node address register,
// history chain and output buffer. Depends on rpdr_pkg, rpdr_history and rpdr_outbuf.
//
//   port group   dir  payload
//   s_*          in   s_tdata: src_addr, dst_addr, pkt_ident, hops_left, data_byte
//   m_*          out  m_tuser: status; m_tdata: delivered_byte .. send_byte
//   cfg_*        in   cfg_wr_data: node_id
//
// One item is accepted per cycle while s_tready is high; its result is registered.
// The decision compares the packet number with all history cells in parallel.
// Reset clears the history valid bits and sets node_id to zero.
// A stalled output holds up to two results; s_tready falls only when both are held.
module packet_receive_dedup_relay #(
  parameter int HISTORY_DEPTH = rpdr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // src_addr, dst_addr, pkt_ident, hops_left, data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // status
  output logic [55:0] m_tdata,   // delivered_byte, was_new, send_valid, send_src,
                                 // send_dst, send_ident, send_hops, send_byte, zero fill
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import rpdr_pkg::*;

  logic [7:0] node_id;
  logic [7:0] src_addr;
  logic [7:0] dst_addr;
  logic [7:0] pkt_ident;
  logic [7:0] hops_left;
  logic [7:0] data_byte;
  logic       s_accept;
  logic       to_me;
  logic       is_ack;
  logic       hit;
  logic       insert;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0;
    end else if (cfg_wr_en) begin
      node_id <= cfg_wr_data;
    end
  end

  assign src_addr  = s_tdata[7:0];
  assign dst_addr  = s_tdata[15:8];
  assign pkt_ident = s_tdata[23:16];
  assign hops_left = s_tdata[31:24];
  assign data_byte = s_tdata[39:32];

  assign s_accept = s_tvalid && s_tready;
  assign to_me    = dst_addr == node_id;
  assign is_ack   = pkt_ident[ACK_FLAG_BIT];
  assign insert   = s_accept && to_me && !is_ack && !hit;

  rpdr_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .insert (insert),
    .probe  (pkt_ident[NUM_W-1:0]),
    .hit    (hit)
  );

  always_comb begin
    res = '0;
    if (!to_me) begin
      res.status = ST_OTHER;
      if (hops_left != 8'd0) begin
        res.send_valid = 1'b1;
        res.send_src   = src_addr;
        res.send_dst   = dst_addr;
        res.send_ident = pkt_ident;
        res.send_hops  = hops_left - 8'd1;
        res.send_byte  = data_byte;
      end
    end else if (is_ack) begin
      res.status = ST_ACK;
    end else begin
      res.status         = ST_DELIVER;
      res.delivered_byte = data_byte;
      res.was_new        = !hit;
      if (!hit) begin
        res.send_valid = 1'b1;
        res.send_src   = node_id;
        res.send_dst   = src_addr;
        res.send_ident = pkt_ident;
        res.send_hops  = ACK_HOPS;
      end
    end
  end

  rpdr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tuser = out_res.status;
  assign m_tdata = {6'b0, out_res.send_byte, out_res.send_hops, out_res.send_ident,
                    out_res.send_dst, out_res.send_src, out_res.send_valid,
                    out_res.was_new, out_res.delivered_byte};

`ifndef SYNTHESIS
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready)
    else $error("input not ready after reset");
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled without a pending result");
  a_ack_fields_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ACK) |-> (m_tdata[9:0] == 10'd0))
    else $error("acknowledgement result carries payload or send request");
  a_new_sends_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[9] && (m_tuser == ST_DELIVER)
      && (m_tdata[41:34] == ACK_HOPS))
    else $error("new packet number without acknowledgement");
`endif
endmodule

// ===== test/packet_receive_dedup_relay_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_receive_dedup_relay: forwarding, acknowledgement and
// duplicate suppression, checked item by item against a predictor under random stalls.
// Depends on rpdr_pkg and the packet_receive_dedup_relay RTL.
module packet_receive_dedup_relay_tb;
  import rpdr_pkg::*;

  localparam int HIST = HISTORY_DEPTH_DEF;

  typedef struct {
    bit [7:0] src;
    bit [7:0] dst;
    bit [7:0] ident;
    bit [7:0] hops;
    bit [7:0] data;
  } rx_hdr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;
  logic [55:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  rx_hdr_t     pending_hdrs[$];
  result_t     expected_results[$];
  rx_hdr_t     offer;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;
  bit          steady = 1'b0;

  // Predictor state: node address and the ring of recently seen packet numbers.
  bit [7:0]    node_addr = '0;
  bit [6:0]    seen_num[HIST];
  bit          seen_ok[HIST];
  int unsigned ring_pos = 0;

  packet_receive_dedup_relay uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tuser    (m_tuser),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit remember_number(bit [6:0] num);
    for (int i = 0; i < HIST; i++) begin
      if (seen_ok[i] && seen_num[i] == num) return 1'b0;
    end
    ring_pos = (ring_pos + 1 >= HIST) ? 0 : ring_pos + 1;
    seen_num[ring_pos] = num;
    seen_ok[ring_pos] = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t relay_decision(rx_hdr_t p);
    result_t r;
    bit      fresh;
    r = '0;
    if (p.dst == node_addr) begin
      if (p.ident[ACK_FLAG_BIT]) begin
        r.status = ST_ACK;
      end else begin
        fresh = remember_number(p.ident[NUM_W-1:0]);
        r.status = ST_DELIVER;
        r.delivered_byte = p.data;
        r.was_new = fresh;
        if (fresh) begin
          r.send_valid = 1'b1;
          r.send_src = node_addr;
          r.send_dst = p.src;
          r.send_ident = p.ident;
          r.send_hops = ACK_HOPS;
        end
      end
    end else begin
      r.status = ST_OTHER;
      if (p.hops != 0) begin
        r.send_valid = 1'b1;
        r.send_src = p.src;
        r.send_dst = p.dst;
        r.send_ident = p.ident;
        r.send_hops = p.hops - 8'd1;
        r.send_byte = p.data;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Sender: offers queued headers with a random gap after each one, except in the steady phase.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(relay_decision(offer));
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0) begin
          s_tvalid <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (pending_hdrs.size() != 0) begin
          offer = pending_hdrs.pop_front();
          s_tdata <= {offer.data, offer.hops, offer.ident, offer.dst, offer.src};
          s_tvalid <= 1'b1;
          tx_wait <= pick_wait();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off partway through the run, so the output buffer fills.
  always @(posedge clk) begin
    if (!stall_done && n_accepted >= 400) begin
      stall_left <= 150;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver: checks each result and then, outside the steady phase, stalls for a random wait.
  always @(posedge clk) begin
    int unsigned wt;
    result_t     want;
    wt = rx_wait;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no expectation pending");
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(m_tuser));
        compare_field("delivered_byte", 32'(want.delivered_byte), 32'(m_tdata[7:0]));
        compare_field("was_new", 32'(want.was_new), 32'(m_tdata[8]));
        compare_field("send_valid", 32'(want.send_valid), 32'(m_tdata[9]));
        compare_field("send_src", 32'(want.send_src), 32'(m_tdata[17:10]));
        compare_field("send_dst", 32'(want.send_dst), 32'(m_tdata[25:18]));
        compare_field("send_ident", 32'(want.send_ident), 32'(m_tdata[33:26]));
        compare_field("send_hops", 32'(want.send_hops), 32'(m_tdata[41:34]));
        compare_field("send_byte", 32'(want.send_byte), 32'(m_tdata[49:42]));
        compare_field("zero_fill", 32'd0, 32'(m_tdata[55:50]));
      end
      n_checked <= n_checked + 1;
      wt = pick_wait();
    end
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (wt != 0) begin
      m_tready <= 1'b0;
      rx_wait <= wt - 1;
    end else begin
      m_tready <= (stall_left == 0);
      rx_wait <= 0;
    end
  end

  task automatic queue_hdr(bit [7:0] src, bit [7:0] dst, bit [7:0] ident, bit [7:0] hops,
                           bit [7:0] data);
    rx_hdr_t p;
    p.src = src;
    p.dst = dst;
    p.ident = ident;
    p.hops = hops;
    p.data = data;
    pending_hdrs.push_back(p);
    n_queued++;
  endtask

  task automatic queue_random_hdr();
    int unsigned sel;
    bit [7:0]    src;
    bit [7:0]    dst;
    bit [7:0]    ident;
    bit [7:0]    hops;
    bit [7:0]    data;
    sel = $urandom_range(0, 99);
    src = 8'($urandom);
    dst = 8'($urandom);
    ident = 8'($urandom);
    hops = 8'($urandom);
    data = 8'($urandom);
    if (sel < 45) begin
      // Payload for this node, numbers mostly from a small pool so repeats are common.
      dst = node_addr;
      ident[7] = 1'b0;
      if ($urandom_range(0, 4) != 0) ident[6:0] = 7'($urandom_range(0, 9));
    end else if (sel < 55) begin
      dst = node_addr;
      ident[7] = 1'b1;
    end else if (sel < 90) begin
      if (dst == node_addr) dst = node_addr + 8'd1;
      case ($urandom_range(0, 3))
        0: hops = 8'd0;
        1: hops = 8'd1;
        default: ;
      endcase
    end
    queue_hdr(src, dst, ident, hops, data);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_queued || n_checked != n_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node(bit [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_addr = v;
  endtask

  initial begin
    bit [7:0]    node_vals[4];
    int unsigned counts[4];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the node address still at its reset value.
    queue_hdr(8'h11, 8'h00, 8'h00, 8'h03, 8'hA5);
    queue_hdr(8'h11, 8'h00, 8'h00, 8'h03, 8'h00);
    queue_hdr(8'h22, 8'h00, 8'h80, 8'h07, 8'h5A);
    queue_hdr(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_hdr(8'h33, 8'h44, 8'h12, 8'h00, 8'h99);
    queue_hdr(8'h33, 8'h44, 8'h12, 8'h01, 8'h99);
    queue_hdr(8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF);
    queue_hdr(8'h00, 8'h01, 8'h00, 8'h80, 8'h00);
    queue_hdr(8'hFF, 8'h00, 8'h7F, 8'h00, 8'hFF);
    queue_hdr(8'h01, 8'h00, 8'h01, 8'h10, 8'h01);
    queue_hdr(8'h02, 8'h00, 8'h02, 8'h10, 8'h02);
    queue_hdr(8'h03, 8'h00, 8'h03, 8'h10, 8'h03);
    queue_hdr(8'h04, 8'h00, 8'h04, 8'h10, 8'h04);
    queue_hdr(8'h05, 8'h00, 8'h00, 8'h10, 8'h05);
    queue_hdr(8'h06, 8'h00, 8'h7F, 8'h10, 8'h06);
    queue_hdr(8'h07, 8'h00, 8'h03, 8'h10, 8'h07);
    queue_hdr(8'h08, 8'h00, 8'h04, 8'h10, 8'h08);
    queue_hdr(8'h09, 8'h00, 8'h84, 8'h10, 8'h09);
    queue_hdr(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    wait_idle();

    node_vals[0] = 8'hFF;
    node_vals[1] = 8'($urandom_range(1, 254));
    node_vals[2] = 8'h00;
    node_vals[3] = 8'($urandom_range(1, 254));
    counts[0] = 220;
    counts[1] = 220;
    counts[2] = 200;
    counts[3] = 210;
    for (int ph = 0; ph < 4; ph++) begin
      write_node(node_vals[ph]);
      steady = (ph == 2);
      for (int k = 0; k < counts[ph]; k++) queue_random_hdr();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpdr_pkg.sv
rtl/rpdr_cell.sv
rtl/rpdr_history.sv
rtl/rpdr_outbuf.sv
rtl/packet_receive_dedup_relay.sv
test/packet_receive_dedup_relay_tb.sv
